// ===== rtl/sdr_pkg.sv =====
// Shared constants, types and helpers of the stereo disparity reprojection core.
// Used by sdr_front, sdr_div, sdr_back and stereo_disparity_reproject_core.
package sdr_pkg;

  // field formats
  localparam int COORD_BITS     = 12;
  localparam int DISP_FRAC_BITS = 4;
  localparam int PIX_FRAC       = 8;
  localparam int DISP_W         = 16;
  localparam int DISP_SHIFT     = PIX_FRAC - DISP_FRAC_BITS;
  localparam int PARAM_W        = 24;
  localparam int BASE_W         = 32;
  localparam int RANGE_W        = 32;
  localparam int RANGE_SHIFT    = 24;
  localparam int PT_W           = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X_RIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE_SQ   = 3'd6;
  localparam logic [RANGE_W-1:0]   RANGE_RESET        = 32'hFFFF_FFFF;

  // stream widths
  localparam int IN_FIELDS_W = 2 * COORD_BITS + DISP_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 3 * PT_W;

  // datapath widths
  localparam int PIXQ_W = COORD_BITS + PIX_FRAC;
  localparam int DIFF_W = PARAM_W + 2;
  localparam int MAG_W  = PARAM_W + 1;
  localparam int WS_W   = PARAM_W + 2;
  localparam int TM_W   = BASE_W;
  localparam int NX_W   = TM_W + MAG_W;
  localparam int NZ_W   = TM_W + PARAM_W;
  localparam int SPLIT  = NZ_W / 2;
  localparam int PL_W   = SPLIT + MAG_W;
  localparam int PH_W   = NZ_W - SPLIT + MAG_W;
  localparam int NY_W   = NZ_W + MAG_W;
  localparam int DY_W   = PARAM_W + MAG_W;
  localparam int NUM_W  = NY_W;
  localparam int DEN_W  = DY_W;
  localparam int REM_W  = DEN_W + 1;
  localparam int Q_BITS = 34;
  localparam int MAGQ_W = Q_BITS + 1;
  localparam int SQ_W   = 2 * PT_W;

  localparam int LANES  = 3;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  localparam logic [PT_W-1:0]   PT_MAX      = 32'h7FFF_FFFF;
  localparam logic [PT_W-1:0]   PT_MIN      = 32'h8000_0000;
  localparam logic [MAGQ_W-1:0] MAG_MAX_POS = MAGQ_W'(64'h7FFF_FFFF);
  localparam logic [MAGQ_W-1:0] MAG_MIN_ABS = MAGQ_W'(64'h8000_0000);

  typedef struct packed {
    logic [PARAM_W-1:0]       focal_x;
    logic [PARAM_W-1:0]       focal_y;
    logic [PARAM_W-1:0]       center_x;
    logic [PARAM_W-1:0]       center_y;
    logic [PARAM_W-1:0]       center_x_right;
    logic signed [BASE_W-1:0] baseline;
    logic [RANGE_W-1:0]       max_range_sq;
  } cfg_t;

  typedef struct packed {
    logic special;
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } side_t;

  typedef logic [LANES-1:0][NUM_W-1:0]  num_vec_t;
  typedef logic [LANES-1:0][DEN_W-1:0]  den_vec_t;
  typedef logic [LANES-1:0][REM_W-1:0]  rem_vec_t;
  typedef logic [LANES-1:0][Q_BITS-1:0] q_vec_t;
  typedef logic [LANES-1:0][MAGQ_W-1:0] magq_vec_t;

  typedef struct packed {
    logic [PT_W-1:0] val;
    logic            sat;
  } sat_t;

  // apply sign to a rounded magnitude and clip to signed 32 bits
  function automatic sat_t sat32(input logic [MAGQ_W-1:0] mag, input logic ovf,
                                 input logic neg);
    sat_t r;
    if (neg) begin
      if (ovf || mag >= MAG_MIN_ABS) begin
        r.val = PT_MIN;
        r.sat = ovf || (mag > MAG_MIN_ABS);
      end else begin
        r.val = -mag[PT_W-1:0];
        r.sat = 1'b0;
      end
    end else if (ovf || mag > MAG_MAX_POS) begin
      r.val = PT_MAX;
      r.sat = 1'b1;
    end else begin
      r.val = mag[PT_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/sdr_front.sv =====
// Front pipeline: pixel offsets, denominator, signs and the numerator products.
// Depends on sdr_pkg; feeds sdr_div.
module sdr_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  sdr_pkg::cfg_t                     cfg,
  input  logic                              in_vld,
  input  logic [sdr_pkg::COORD_BITS-1:0]    column,
  input  logic [sdr_pkg::COORD_BITS-1:0]    row,
  input  logic [sdr_pkg::DISP_W-1:0]        disparity,
  output logic                              out_vld,
  output sdr_pkg::num_vec_t                 out_num,
  output sdr_pkg::den_vec_t                 out_den,
  output sdr_pkg::side_t                    out_side
);

  // stage 0: input capture
  logic                           vld0_r;
  logic [sdr_pkg::COORD_BITS-1:0] u0_r, v0_r;
  logic [sdr_pkg::DISP_W-1:0]     d0_r;

  // stage 1: offsets and denominator
  logic                       vld1_r;
  logic [sdr_pkg::DIFF_W-1:0] du1_r, dv1_r, du1_nxt, dv1_nxt;
  logic [sdr_pkg::WS_W-1:0]   w1_r, w1_nxt;
  logic                       dz1_r;
  logic [sdr_pkg::PIXQ_W-1:0] u8, v8;

  // stage 2: magnitudes and signs
  logic                      vld2_r;
  logic [sdr_pkg::MAG_W-1:0] dum2_r, dvm2_r, wm2_r, dum2_nxt, dvm2_nxt, wm2_nxt;
  sdr_pkg::side_t            side2_r, side2_nxt;

  // stage 3: first products
  logic                      vld3_r;
  logic [sdr_pkg::TM_W-1:0]  tm;
  logic [sdr_pkg::NX_W-1:0]  nx3_r, nx3_nxt;
  logic [sdr_pkg::NZ_W-1:0]  nz3_r, nz3_nxt;
  logic [sdr_pkg::DY_W-1:0]  dy3_r, dy3_nxt;
  logic [sdr_pkg::MAG_W-1:0] dvm3_r, wm3_r;
  sdr_pkg::side_t            side3_r;

  // stage 4: partial products of the Y numerator
  logic                      vld4_r;
  logic [sdr_pkg::PL_W-1:0]  pl4_r, pl4_nxt;
  logic [sdr_pkg::PH_W-1:0]  ph4_r, ph4_nxt;
  logic [sdr_pkg::NX_W-1:0]  nx4_r;
  logic [sdr_pkg::NZ_W-1:0]  nz4_r;
  logic [sdr_pkg::DY_W-1:0]  dy4_r;
  logic [sdr_pkg::MAG_W-1:0] wm4_r;
  sdr_pkg::side_t            side4_r;

  // stage 5: dividend and divisor sets
  logic                 vld5_r;
  logic [sdr_pkg::NY_W-1:0] ny5_nxt;
  sdr_pkg::num_vec_t    num5_r, num5_nxt;
  sdr_pkg::den_vec_t    den5_r, den5_nxt;
  sdr_pkg::side_t       side5_r;

  always_comb begin
    u8      = {u0_r, {sdr_pkg::PIX_FRAC{1'b0}}};
    v8      = {v0_r, {sdr_pkg::PIX_FRAC{1'b0}}};
    du1_nxt = sdr_pkg::DIFF_W'(u8) - sdr_pkg::DIFF_W'(cfg.center_x);
    dv1_nxt = sdr_pkg::DIFF_W'(v8) - sdr_pkg::DIFF_W'(cfg.center_y);
    w1_nxt  = sdr_pkg::WS_W'(cfg.center_x) - sdr_pkg::WS_W'(cfg.center_x_right)
            - (sdr_pkg::WS_W'(d0_r) << sdr_pkg::DISP_SHIFT);
  end

  always_comb begin
    dum2_nxt = du1_r[sdr_pkg::DIFF_W-1] ? sdr_pkg::MAG_W'(-du1_r) : sdr_pkg::MAG_W'(du1_r);
    dvm2_nxt = dv1_r[sdr_pkg::DIFF_W-1] ? sdr_pkg::MAG_W'(-dv1_r) : sdr_pkg::MAG_W'(dv1_r);
    wm2_nxt  = w1_r[sdr_pkg::WS_W-1] ? sdr_pkg::MAG_W'(-w1_r) : sdr_pkg::MAG_W'(w1_r);
    side2_nxt.special = dz1_r || (w1_r == '0) || (cfg.focal_y == '0);
    side2_nxt.neg_x   = cfg.baseline[sdr_pkg::BASE_W-1] ^ w1_r[sdr_pkg::WS_W-1];
    side2_nxt.neg_y   = cfg.baseline[sdr_pkg::BASE_W-1] ^ w1_r[sdr_pkg::WS_W-1]
                      ^ dv1_r[sdr_pkg::DIFF_W-1];
    side2_nxt.neg_z   = cfg.baseline[sdr_pkg::BASE_W-1] ^ w1_r[sdr_pkg::WS_W-1];
  end

  always_comb begin
    tm      = cfg.baseline[sdr_pkg::BASE_W-1] ? sdr_pkg::TM_W'(-cfg.baseline)
                                              : sdr_pkg::TM_W'(cfg.baseline);
    nx3_nxt = tm * dum2_r;
    nz3_nxt = tm * cfg.focal_x;
    dy3_nxt = cfg.focal_y * wm2_r;
  end

  always_comb begin
    pl4_nxt = nz3_r[sdr_pkg::SPLIT-1:0] * dvm3_r;
    ph4_nxt = nz3_r[sdr_pkg::NZ_W-1:sdr_pkg::SPLIT] * dvm3_r;
  end

  always_comb begin
    ny5_nxt = (sdr_pkg::NY_W'(ph4_r) << sdr_pkg::SPLIT) + sdr_pkg::NY_W'(pl4_r);
    num5_nxt[sdr_pkg::LANE_X] = sdr_pkg::NUM_W'(nx4_r);
    num5_nxt[sdr_pkg::LANE_Y] = ny5_nxt;
    num5_nxt[sdr_pkg::LANE_Z] = sdr_pkg::NUM_W'(nz4_r);
    den5_nxt[sdr_pkg::LANE_X] = sdr_pkg::DEN_W'(wm4_r);
    den5_nxt[sdr_pkg::LANE_Y] = dy4_r;
    den5_nxt[sdr_pkg::LANE_Z] = sdr_pkg::DEN_W'(wm4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_vld;
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u0_r    <= column;
      v0_r    <= row;
      d0_r    <= disparity;
      du1_r   <= du1_nxt;
      dv1_r   <= dv1_nxt;
      w1_r    <= w1_nxt;
      dz1_r   <= (d0_r == '0);
      dum2_r  <= dum2_nxt;
      dvm2_r  <= dvm2_nxt;
      wm2_r   <= wm2_nxt;
      side2_r <= side2_nxt;
      nx3_r   <= nx3_nxt;
      nz3_r   <= nz3_nxt;
      dy3_r   <= dy3_nxt;
      dvm3_r  <= dvm2_r;
      wm3_r   <= wm2_r;
      side3_r <= side2_r;
      pl4_r   <= pl4_nxt;
      ph4_r   <= ph4_nxt;
      nx4_r   <= nx3_r;
      nz4_r   <= nz3_r;
      dy4_r   <= dy3_r;
      wm4_r   <= wm3_r;
      side4_r <= side3_r;
      num5_r  <= num5_nxt;
      den5_r  <= den5_nxt;
      side5_r <= side4_r;
    end
  end

  assign out_vld  = vld5_r;
  assign out_num  = num5_r;
  assign out_den  = den5_r;
  assign out_side = side5_r;

  // a point that is not flagged special must reach the divider with a live Y divisor
  a_den_live: assert property (@(posedge clk) disable iff (!rst_n)
    vld5_r && !side5_r.special |-> den5_r[sdr_pkg::LANE_Y] != '0)
    else $error("nonzero Y divisor expected for a regular point");

endmodule

// ===== rtl/sdr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes in lockstep.
// Depends on sdr_pkg; sits between sdr_front and sdr_back.
module sdr_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  sdr_pkg::num_vec_t                  in_num,
  input  sdr_pkg::den_vec_t                  in_den,
  input  sdr_pkg::side_t                     in_side,
  output logic                               out_vld,
  output sdr_pkg::q_vec_t                    out_q,
  output sdr_pkg::rem_vec_t                  out_rem,
  output sdr_pkg::den_vec_t                  out_den,
  output logic [sdr_pkg::LANES-1:0]          out_ovf,
  output sdr_pkg::side_t                     out_side
);

  logic                             vld_r  [sdr_pkg::Q_BITS+1];
  sdr_pkg::rem_vec_t                rem_r  [sdr_pkg::Q_BITS+1];
  sdr_pkg::q_vec_t                  low_r  [sdr_pkg::Q_BITS+1];
  sdr_pkg::den_vec_t                den_r  [sdr_pkg::Q_BITS+1];
  logic [sdr_pkg::LANES-1:0]        ovf_r  [sdr_pkg::Q_BITS+1];
  sdr_pkg::side_t                   side_r [sdr_pkg::Q_BITS+1];

  sdr_pkg::rem_vec_t                rem0_nxt;
  sdr_pkg::q_vec_t                  low0_nxt;
  logic [sdr_pkg::LANES-1:0]        ovf0_nxt;

  // entry: quotients of 2^Q_BITS or more are flagged, the rest start here
  always_comb begin
    for (int k = 0; k < sdr_pkg::LANES; k++) begin
      rem0_nxt[k] = sdr_pkg::REM_W'(in_num[k][sdr_pkg::NUM_W-1:sdr_pkg::Q_BITS]);
      low0_nxt[k] = in_num[k][sdr_pkg::Q_BITS-1:0];
      ovf0_nxt[k] = rem0_nxt[k] >= sdr_pkg::REM_W'(in_den[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem0_nxt;
      low_r[0]  <= low0_nxt;
      den_r[0]  <= in_den;
      ovf_r[0]  <= ovf0_nxt;
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 0; s < sdr_pkg::Q_BITS; s++) begin : g_stage
    sdr_pkg::rem_vec_t rem_nxt;
    sdr_pkg::q_vec_t   low_nxt;

    // shift in the next dividend bit, subtract when it fits, shift the quotient bit in
    always_comb begin
      logic [sdr_pkg::REM_W-1:0] trial;
      logic [sdr_pkg::REM_W-1:0] dext;
      for (int k = 0; k < sdr_pkg::LANES; k++) begin
        trial = {rem_r[s][k][sdr_pkg::REM_W-2:0], low_r[s][k][sdr_pkg::Q_BITS-1]};
        dext  = sdr_pkg::REM_W'(den_r[s][k]);
        if (trial >= dext) begin
          rem_nxt[k] = trial - dext;
          low_nxt[k] = {low_r[s][k][sdr_pkg::Q_BITS-2:0], 1'b1};
        end else begin
          rem_nxt[k] = trial;
          low_nxt[k] = {low_r[s][k][sdr_pkg::Q_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= rem_nxt;
        low_r[s+1]  <= low_nxt;
        den_r[s+1]  <= den_r[s];
        ovf_r[s+1]  <= ovf_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_vld  = vld_r[sdr_pkg::Q_BITS];
  assign out_q    = low_r[sdr_pkg::Q_BITS];
  assign out_rem  = rem_r[sdr_pkg::Q_BITS];
  assign out_den  = den_r[sdr_pkg::Q_BITS];
  assign out_ovf  = ovf_r[sdr_pkg::Q_BITS];
  assign out_side = side_r[sdr_pkg::Q_BITS];

  a_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[sdr_pkg::Q_BITS] && !ovf_r[sdr_pkg::Q_BITS][sdr_pkg::LANE_X]
      && den_r[sdr_pkg::Q_BITS][sdr_pkg::LANE_X] != '0
    |-> rem_r[sdr_pkg::Q_BITS][sdr_pkg::LANE_X]
          < sdr_pkg::REM_W'(den_r[sdr_pkg::Q_BITS][sdr_pkg::LANE_X]))
    else $error("X lane remainder not below divisor");

  a_rem_y: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[sdr_pkg::Q_BITS] && !ovf_r[sdr_pkg::Q_BITS][sdr_pkg::LANE_Y]
      && den_r[sdr_pkg::Q_BITS][sdr_pkg::LANE_Y] != '0
    |-> rem_r[sdr_pkg::Q_BITS][sdr_pkg::LANE_Y]
          < sdr_pkg::REM_W'(den_r[sdr_pkg::Q_BITS][sdr_pkg::LANE_Y]))
    else $error("Y lane remainder not below divisor");

endmodule

// ===== rtl/sdr_back.sv =====
// Back pipeline: rounding, sign and saturation, squared range test, output register.
// Depends on sdr_pkg; fed by sdr_div.
module sdr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [sdr_pkg::RANGE_W-1:0]   max_range_sq,
  input  logic                          in_vld,
  input  sdr_pkg::q_vec_t               in_q,
  input  sdr_pkg::rem_vec_t             in_rem,
  input  sdr_pkg::den_vec_t             in_den,
  input  logic [sdr_pkg::LANES-1:0]     in_ovf,
  input  sdr_pkg::side_t                in_side,
  output logic                          out_vld,
  output logic [sdr_pkg::PT_W-1:0]      point_x,
  output logic [sdr_pkg::PT_W-1:0]      point_y,
  output logic [sdr_pkg::PT_W-1:0]      point_z,
  output logic                          point_valid
);

  // stage 0: round half up
  logic                      vld0_r;
  sdr_pkg::magq_vec_t        mag0_r, mag0_nxt;
  logic [sdr_pkg::LANES-1:0] ovf0_r;
  sdr_pkg::side_t            side0_r;

  // stage 1: signed and clipped coordinates
  logic                     vld1_r;
  logic [sdr_pkg::PT_W-1:0] x1_r, y1_r, z1_r, x1_nxt, y1_nxt, z1_nxt;
  logic                     vz1_r, vz1_nxt;
  sdr_pkg::sat_t            sx, sy, sz;

  // stage 2: squares
  logic                     vld2_r;
  logic [sdr_pkg::PT_W-1:0] ax, ay, az;
  logic [sdr_pkg::SQ_W-1:0] sqx2_r, sqy2_r, sqz2_r;
  logic [sdr_pkg::PT_W-1:0] x2_r, y2_r, z2_r;
  logic                     vz2_r;

  // stage 3: sum of squares
  logic                     vld3_r;
  logic [sdr_pkg::SQ_W-1:0] sum3_r;
  logic [sdr_pkg::PT_W-1:0] x3_r, y3_r, z3_r;
  logic                     vz3_r;

  // stage 4: output register
  logic                     vld4_r;
  logic [sdr_pkg::PT_W-1:0] x4_r, y4_r, z4_r;
  logic                     pv4_r, pv4_nxt;
  logic [sdr_pkg::SQ_W-1:0] limit;

  always_comb begin
    logic rnd;
    for (int k = 0; k < sdr_pkg::LANES; k++) begin
      rnd = {in_rem[k], 1'b0} >= {2'b00, in_den[k]};
      mag0_nxt[k] = sdr_pkg::MAGQ_W'(in_q[k]) + sdr_pkg::MAGQ_W'(rnd);
    end
  end

  always_comb begin
    sx = sdr_pkg::sat32(mag0_r[sdr_pkg::LANE_X], ovf0_r[sdr_pkg::LANE_X], side0_r.neg_x);
    sy = sdr_pkg::sat32(mag0_r[sdr_pkg::LANE_Y], ovf0_r[sdr_pkg::LANE_Y], side0_r.neg_y);
    sz = sdr_pkg::sat32(mag0_r[sdr_pkg::LANE_Z], ovf0_r[sdr_pkg::LANE_Z], side0_r.neg_z);
    if (side0_r.special) begin
      x1_nxt  = sdr_pkg::PT_MAX;
      y1_nxt  = sdr_pkg::PT_MAX;
      z1_nxt  = sdr_pkg::PT_MAX;
      vz1_nxt = 1'b0;
    end else begin
      x1_nxt  = sx.val;
      y1_nxt  = sy.val;
      z1_nxt  = sz.val;
      vz1_nxt = !sz.sat && !sz.val[sdr_pkg::PT_W-1] && (sz.val != '0);
    end
  end

  always_comb begin
    ax = x1_r[sdr_pkg::PT_W-1] ? -x1_r : x1_r;
    ay = y1_r[sdr_pkg::PT_W-1] ? -y1_r : y1_r;
    az = z1_r[sdr_pkg::PT_W-1] ? -z1_r : z1_r;
  end

  always_comb begin
    limit   = sdr_pkg::SQ_W'({max_range_sq, {sdr_pkg::RANGE_SHIFT{1'b0}}});
    pv4_nxt = vz3_r && (sum3_r < limit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_vld;
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0_r  <= mag0_nxt;
      ovf0_r  <= in_ovf;
      side0_r <= in_side;
      x1_r    <= x1_nxt;
      y1_r    <= y1_nxt;
      z1_r    <= z1_nxt;
      vz1_r   <= vz1_nxt;
      sqx2_r  <= ax * ax;
      sqy2_r  <= ay * ay;
      sqz2_r  <= az * az;
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      z2_r    <= z1_r;
      vz2_r   <= vz1_r;
      sum3_r  <= sqx2_r + sqy2_r + sqz2_r;
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      z3_r    <= z2_r;
      vz3_r   <= vz2_r;
      x4_r    <= x3_r;
      y4_r    <= y3_r;
      z4_r    <= z3_r;
      pv4_r   <= pv4_nxt;
    end
  end

  assign out_vld     = vld4_r;
  assign point_x     = x4_r;
  assign point_y     = y4_r;
  assign point_z     = z4_r;
  assign point_valid = pv4_r;

  // the range limit tops out below 2^56, so a valid point has small coordinates
  a_valid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld4_r && pv4_r |-> (z4_r[sdr_pkg::PT_W-1:sdr_pkg::PT_W-4] == 4'h0)
      && ((x4_r[sdr_pkg::PT_W-1:sdr_pkg::PT_W-4] == 4'h0)
          || (x4_r[sdr_pkg::PT_W-1:sdr_pkg::PT_W-4] == 4'hF)))
    else $error("valid point outside the reachable range");

  a_valid_depth: assert property (@(posedge clk) disable iff (!rst_n)
    vld4_r && pv4_r |-> z4_r != '0)
    else $error("valid point with zero depth");

endmodule

// ===== rtl/stereo_disparity_reproject_core.sv =====
// Top level of the stereo disparity to 3D point core: config registers, stall control.
// Depends on sdr_pkg, sdr_front, sdr_div and sdr_back.
//
//   port group | dir | moves
//   in_*       | in  | one pixel item: column, row, disparity
//   out_*      | out | one point item: point_x, point_y, point_z; point_valid in tuser
//   cfg_*      | in  | register writes, no handshake
//
// One item per clock while the output is not stalled; an item passes 6 front stages,
// 35 divider stages (one quotient bit each, 34 bits plus entry) and 5 back stages.
// The whole pipeline advances when the output register is empty or taken; a stall
// freezes every stage, so nothing is lost or repeated.
// Synchronous active-low reset clears the valid bits and loads register defaults.
module stereo_disparity_reproject_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [sdr_pkg::IN_TDATA_W-1:0]     in_tdata,   // column, row, disparity
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [sdr_pkg::OUT_TDATA_W-1:0]    out_tdata,  // point_x, point_y, point_z
  output logic                               out_tuser,  // point_valid
  input  logic                               cfg_wen,
  input  logic [sdr_pkg::CFG_IDX_W-1:0]      cfg_waddr,
  input  logic [sdr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  sdr_pkg::cfg_t            cfg_r;
  logic                     adv;
  logic                     f_vld, d_vld, b_vld;
  sdr_pkg::num_vec_t        f_num;
  sdr_pkg::den_vec_t        f_den, d_den;
  sdr_pkg::side_t           f_side, d_side;
  sdr_pkg::q_vec_t          d_q;
  sdr_pkg::rem_vec_t        d_rem;
  logic [sdr_pkg::LANES-1:0] d_ovf;
  logic [sdr_pkg::PT_W-1:0] px, py, pz;
  logic                     pv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal_x        <= '0;
      cfg_r.focal_y        <= '0;
      cfg_r.center_x       <= '0;
      cfg_r.center_y       <= '0;
      cfg_r.center_x_right <= '0;
      cfg_r.baseline       <= '0;
      cfg_r.max_range_sq   <= sdr_pkg::RANGE_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_waddr)
        sdr_pkg::CFG_FOCAL_X:        cfg_r.focal_x        <= cfg_wdata[sdr_pkg::PARAM_W-1:0];
        sdr_pkg::CFG_FOCAL_Y:        cfg_r.focal_y        <= cfg_wdata[sdr_pkg::PARAM_W-1:0];
        sdr_pkg::CFG_CENTER_X:       cfg_r.center_x       <= cfg_wdata[sdr_pkg::PARAM_W-1:0];
        sdr_pkg::CFG_CENTER_Y:       cfg_r.center_y       <= cfg_wdata[sdr_pkg::PARAM_W-1:0];
        sdr_pkg::CFG_CENTER_X_RIGHT: cfg_r.center_x_right <= cfg_wdata[sdr_pkg::PARAM_W-1:0];
        sdr_pkg::CFG_BASELINE:       cfg_r.baseline       <= cfg_wdata[sdr_pkg::BASE_W-1:0];
        sdr_pkg::CFG_MAX_RANGE_SQ:   cfg_r.max_range_sq   <= cfg_wdata[sdr_pkg::RANGE_W-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // advance everything unless a finished point is waiting
  assign adv       = !b_vld || out_tready;
  assign in_tready = adv;

  sdr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .cfg       (cfg_r),
    .in_vld    (in_tvalid),
    .column    (in_tdata[sdr_pkg::COORD_BITS-1:0]),
    .row       (in_tdata[2*sdr_pkg::COORD_BITS-1:sdr_pkg::COORD_BITS]),
    .disparity (in_tdata[sdr_pkg::IN_FIELDS_W-1:2*sdr_pkg::COORD_BITS]),
    .out_vld   (f_vld),
    .out_num   (f_num),
    .out_den   (f_den),
    .out_side  (f_side)
  );

  sdr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (f_vld),
    .in_num   (f_num),
    .in_den   (f_den),
    .in_side  (f_side),
    .out_vld  (d_vld),
    .out_q    (d_q),
    .out_rem  (d_rem),
    .out_den  (d_den),
    .out_ovf  (d_ovf),
    .out_side (d_side)
  );

  sdr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .max_range_sq (cfg_r.max_range_sq),
    .in_vld       (d_vld),
    .in_q         (d_q),
    .in_rem       (d_rem),
    .in_den       (d_den),
    .in_ovf       (d_ovf),
    .in_side      (d_side),
    .out_vld      (b_vld),
    .point_x      (px),
    .point_y      (py),
    .point_z      (pz),
    .point_valid  (pv)
  );

  assign out_tvalid = b_vld;
  assign out_tdata  = {pz, py, px};
  assign out_tuser  = pv;

endmodule
